[rtl/bpms_pkg.sv]
// shared types, codes and timing constants for the buzzer pattern and melody sequencer
`timescale 1ns / 1ps

package bpms_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_PATTERN = 3'd1,
        OP_LOAD    = 3'd2,
        OP_MELODY  = 3'd3,
        OP_STOP    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        PAT_SINGLE = 3'd0,
        PAT_DOUBLE = 3'd1,
        PAT_TRIPLE = 3'd2,
        PAT_ALARM  = 3'd3,
        PAT_NOTIFY = 3'd4
    } pat_kind_t;

    typedef enum logic [1:0] {
        ACT_NONE = 2'd0,
        ACT_ON   = 2'd1,
        ACT_OFF  = 2'd2,
        ACT_END  = 2'd3
    } pat_act_t;

    typedef enum logic {
        REG_BLOCK_ENABLED = 1'b0,
        REG_TONE_MODE     = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] duration;
    } note_t;

    localparam logic [15:0] BEEP_HZ       = 16'd2000;
    localparam logic [15:0] ALARM_HZ      = 16'd1200;
    localparam logic [11:0] ALARM_END_MS  = 12'd3000;
    localparam logic [11:0] PT_MAX        = 12'd4095;
    localparam logic [15:0] NT_MAX        = 16'd65535;

    // drive action of a running pattern at elapsed time t
    function automatic pat_act_t pattern_action(input pat_kind_t kind, input logic [11:0] t);
        pat_act_t act;
        logic     even_half;
        act       = ACT_NONE;
        // alarm toggles every 500 ms: even halves are on
        even_half = (t < 12'd500) || ((t >= 12'd1000) && (t < 12'd1500))
                    || ((t >= 12'd2000) && (t < 12'd2500))
                    || ((t >= 12'd3000) && (t < 12'd3500)) || (t >= 12'd4000);
        case (kind)
            PAT_SINGLE:
            begin
                if (t < 12'd100)      act = ACT_ON;
                else if (t < 12'd200) act = ACT_END;
            end
            PAT_DOUBLE:
            begin
                if (t < 12'd100)      act = ACT_ON;
                else if (t < 12'd150) act = ACT_OFF;
                else if (t < 12'd250) act = ACT_ON;
                else if (t < 12'd350) act = ACT_END;
            end
            PAT_TRIPLE:
            begin
                if (t < 12'd80)       act = ACT_ON;
                else if (t < 12'd120) act = ACT_OFF;
                else if (t < 12'd200) act = ACT_ON;
                else if (t < 12'd240) act = ACT_OFF;
                else if (t < 12'd320) act = ACT_ON;
                else if (t < 12'd400) act = ACT_END;
            end
            PAT_ALARM:
            begin
                if (t > ALARM_END_MS) act = ACT_END;
                else if (even_half)   act = ACT_ON;
                else                  act = ACT_OFF;
            end
            PAT_NOTIFY:
            begin
                if (t < 12'd50)       act = ACT_ON;
                else if (t < 12'd100) act = ACT_OFF;
                else if (t < 12'd150) act = ACT_ON;
                else if (t < 12'd200) act = ACT_END;
            end
            default:
            begin
                act = ACT_NONE;
            end
        endcase
        return act;
    endfunction

endpackage

[rtl/buzzer_pattern_melody_sequencer.sv]
// buzzer pattern and melody sequencer: input register, note store, state update, result
`timescale 1ns / 1ps

// path: an item passes the input register, then the state update, which is also the result register
// throughput: one item per cycle while out_ready stays high; the note store has two registered read ports
//   addressed from the next state, with forwarding of the last write
// reset: all control and sequencing state clears at once; the note store is not cleared
//   and needs no clearing pass, so items are accepted right after reset
module buzzer_pattern_melody_sequencer #(
    parameter int MAX_NOTES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [2:0]  pattern_id,
    input  logic [5:0]  note_index,
    input  logic [15:0] note_freq,
    input  logic [15:0] note_duration,
    input  logic [6:0]  melody_length,
    input  logic        cancel_pattern,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] tone_freq,
    output logic        pin_high,
    output logic        pattern_active,
    output logic        melody_active
);

    localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int CNT_W = $clog2(MAX_NOTES + 1);

    // configuration
    logic block_enabled_reg;
    logic tone_mode_reg;

    // input register
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic [2:0]  pid_reg;
    logic [5:0]  idx_reg;
    logic [15:0] freq_reg;
    logic [15:0] dur_reg;
    logic [6:0]  len_reg;
    logic        cancel_reg;

    // sequencing state, also the result register
    logic                    out_valid_reg;
    logic [11:0]             pattern_time_reg, pattern_time_next;
    bpms_pkg::pat_kind_t     pattern_kind_reg, pattern_kind_next;
    logic                    pattern_running_reg, pattern_running_next;
    logic [IDX_W-1:0]        note_position_reg, note_position_next;
    logic [CNT_W-1:0]        notes_in_melody_reg, notes_in_melody_next;
    logic [15:0]             note_time_reg, note_time_next;
    logic                    melody_running_reg, melody_running_next;
    logic [15:0]             tone_register_reg, tone_register_next;
    logic                    pin_register_reg, pin_register_next;

    // note store
    bpms_pkg::note_t  note_mem [MAX_NOTES];
    bpms_pkg::note_t  rd_a_reg, rd_b_reg;
    logic [IDX_W-1:0] rd_addr_a_reg, rd_addr_b_reg;
    logic [IDX_W-1:0] rd_addr_a, rd_addr_b;
    logic             last_wr_en_reg;
    logic [IDX_W-1:0] last_wr_addr_reg;
    bpms_pkg::note_t  last_wr_data_reg;
    bpms_pkg::note_t  cur_note, next_note;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    bpms_pkg::note_t  wr_data;

    logic                 in_transfer;
    logic                 fire;
    logic [2:0]           next_op;
    bpms_pkg::op_t        op;
    bpms_pkg::pat_act_t   act;
    logic [15:0]          pat_hz;
    logic [11:0]          pt_inc;
    logic [15:0]          nt_inc;
    logic [CNT_W-1:0]     pos_plus;
    logic [CNT_W-1:0]     len_sat;

    assign fire        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready    = !in_valid_reg || fire;
    assign in_transfer = in_valid && in_ready;

    assign out_valid      = out_valid_reg;
    assign tone_freq      = tone_register_reg;
    assign pin_high       = pin_register_reg;
    assign pattern_active = pattern_running_reg;
    assign melody_active  = melody_running_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_enabled_reg <= 1'b0;
            tone_mode_reg     <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (bpms_pkg::cfg_reg_t'(cfg_index))
                bpms_pkg::REG_BLOCK_ENABLED: block_enabled_reg <= cfg_data;
                bpms_pkg::REG_TONE_MODE:     tone_mode_reg     <= cfg_data;
                default:                     tone_mode_reg     <= tone_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_transfer)
                in_valid_reg <= 1'b1;
            else if (fire)
                in_valid_reg <= 1'b0;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            op_reg     <= operation;
            pid_reg    <= pattern_id;
            idx_reg    <= note_index;
            freq_reg   <= note_freq;
            dur_reg    <= note_duration;
            len_reg    <= melody_length;
            cancel_reg <= cancel_pattern;
        end
    end

    // reads are addressed from the next state so the data lines up with the item in the input register
    assign next_op   = in_transfer ? operation : op_reg;
    assign rd_addr_a = note_position_next;
    assign rd_addr_b = (next_op == bpms_pkg::OP_MELODY) ? '0
                       : note_position_next + IDX_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            note_mem[wr_addr] <= wr_data;
        rd_a_reg         <= note_mem[rd_addr_a];
        rd_b_reg         <= note_mem[rd_addr_b];
        rd_addr_a_reg    <= rd_addr_a;
        rd_addr_b_reg    <= rd_addr_b;
        last_wr_addr_reg <= wr_addr;
        last_wr_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_wr_en_reg <= 1'b0;
        else
            last_wr_en_reg <= wr_en;
    end

    // a write on the same edge as the read is not yet in the read data
    assign cur_note  = (last_wr_en_reg && (last_wr_addr_reg == rd_addr_a_reg))
                       ? last_wr_data_reg : rd_a_reg;
    assign next_note = (last_wr_en_reg && (last_wr_addr_reg == rd_addr_b_reg))
                       ? last_wr_data_reg : rd_b_reg;

    assign op      = bpms_pkg::op_t'(op_reg);
    assign pt_inc  = (pattern_time_reg < bpms_pkg::PT_MAX) ? pattern_time_reg + 12'd1
                     : pattern_time_reg;
    assign act     = bpms_pkg::pattern_action(pattern_kind_reg, pt_inc);
    assign pat_hz  = (pattern_kind_reg == bpms_pkg::PAT_ALARM) ? bpms_pkg::ALARM_HZ
                     : bpms_pkg::BEEP_HZ;
    assign nt_inc  = (note_time_reg < bpms_pkg::NT_MAX) ? note_time_reg + 16'd1 : note_time_reg;
    assign pos_plus = CNT_W'(note_position_reg) + CNT_W'(1);
    assign len_sat = (32'(len_reg) > MAX_NOTES) ? CNT_W'(MAX_NOTES) : CNT_W'(len_reg);
    assign wr_addr = IDX_W'(idx_reg);
    assign wr_data = '{freq: freq_reg, duration: dur_reg};
    assign wr_en   = fire && block_enabled_reg && (op == bpms_pkg::OP_LOAD)
                     && (32'(idx_reg) < MAX_NOTES);

    always_comb
    begin
        pattern_time_next    = pattern_time_reg;
        pattern_kind_next    = pattern_kind_reg;
        pattern_running_next = pattern_running_reg;
        note_position_next   = note_position_reg;
        notes_in_melody_next = notes_in_melody_reg;
        note_time_next       = note_time_reg;
        melody_running_next  = melody_running_reg;
        tone_register_next   = tone_register_reg;
        pin_register_next    = pin_register_reg;
        if (fire && block_enabled_reg)
        begin
            case (op)
                bpms_pkg::OP_TICK:
                begin
                    pattern_time_next = pt_inc;
                    if (melody_running_reg)
                    begin
                        note_time_next = nt_inc;
                        if ((CNT_W'(note_position_reg) < notes_in_melody_reg)
                            && (nt_inc >= cur_note.duration))
                        begin
                            if (tone_mode_reg) tone_register_next = 16'd0;
                            else               pin_register_next  = 1'b0;
                            if (pos_plus >= notes_in_melody_reg)
                            begin
                                melody_running_next  = 1'b0;
                                notes_in_melody_next = '0;
                                note_position_next   = '0;
                            end
                            else
                            begin
                                note_position_next = note_position_reg + IDX_W'(1);
                                note_time_next     = 16'd0;
                                if (next_note.freq != 16'd0)
                                begin
                                    if (tone_mode_reg) tone_register_next = next_note.freq;
                                    else               pin_register_next  = 1'b1;
                                end
                            end
                        end
                    end
                    else if (pattern_running_reg)
                    begin
                        case (act)
                            bpms_pkg::ACT_ON:
                            begin
                                if (tone_mode_reg) tone_register_next = pat_hz;
                                else               pin_register_next  = 1'b1;
                            end
                            bpms_pkg::ACT_OFF:
                            begin
                                if (tone_mode_reg) tone_register_next = 16'd0;
                                else               pin_register_next  = 1'b0;
                            end
                            bpms_pkg::ACT_END:
                            begin
                                if (tone_mode_reg) tone_register_next = 16'd0;
                                else               pin_register_next  = 1'b0;
                                pattern_running_next = 1'b0;
                            end
                            default:
                            begin
                                pattern_running_next = pattern_running_reg;
                            end
                        endcase
                    end
                end
                bpms_pkg::OP_PATTERN:
                begin
                    if (pid_reg <= 3'd4)
                    begin
                        pattern_kind_next    = bpms_pkg::pat_kind_t'(pid_reg);
                        pattern_time_next    = 12'd0;
                        pattern_running_next = 1'b1;
                    end
                end
                bpms_pkg::OP_MELODY:
                begin
                    if (len_reg != 7'd0)
                    begin
                        if (cancel_reg)
                        begin
                            pattern_running_next = 1'b0;
                            pattern_kind_next    = bpms_pkg::PAT_NOTIFY;
                        end
                        notes_in_melody_next = len_sat;
                        note_position_next   = '0;
                        note_time_next       = 16'd0;
                        melody_running_next  = 1'b1;
                        // a rest as first note leaves the drive as it was
                        if (next_note.freq != 16'd0)
                        begin
                            if (tone_mode_reg) tone_register_next = next_note.freq;
                            else               pin_register_next  = 1'b1;
                        end
                    end
                end
                bpms_pkg::OP_STOP:
                begin
                    if (tone_mode_reg) tone_register_next = 16'd0;
                    else               pin_register_next  = 1'b0;
                    pattern_running_next = 1'b0;
                end
                default:
                begin
                    // load note only touches the store; unused codes change nothing
                    pattern_running_next = pattern_running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_time_reg    <= 12'd0;
            pattern_kind_reg    <= bpms_pkg::PAT_SINGLE;
            pattern_running_reg <= 1'b0;
            note_position_reg   <= '0;
            notes_in_melody_reg <= '0;
            note_time_reg       <= 16'd0;
            melody_running_reg  <= 1'b0;
            tone_register_reg   <= 16'd0;
            pin_register_reg    <= 1'b0;
        end
        else
        begin
            pattern_time_reg    <= pattern_time_next;
            pattern_kind_reg    <= pattern_kind_next;
            pattern_running_reg <= pattern_running_next;
            note_position_reg   <= note_position_next;
            notes_in_melody_reg <= notes_in_melody_next;
            note_time_reg       <= note_time_next;
            melody_running_reg  <= melody_running_next;
            tone_register_reg   <= tone_register_next;
            pin_register_reg    <= pin_register_next;
        end
    end

    // an idle melody leaves no position or count behind
    a_idle_melody_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !melody_running_reg |-> (note_position_reg == '0) && (notes_in_melody_reg == '0))
        else $error("melody idle with stale position or count");

    a_position_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        melody_running_reg |-> (CNT_W'(note_position_reg) < notes_in_melody_reg))
        else $error("note position beyond melody length");

    a_disabled_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !block_enabled_reg |=> $stable(pattern_time_reg) && $stable(note_time_reg)
            && $stable(tone_register_reg) && $stable(melody_running_reg))
        else $error("state changed while block disabled");

    a_pattern_start: assert property (@(posedge clk) disable iff (!rst_n)
        fire && block_enabled_reg && (op_reg == bpms_pkg::OP_PATTERN) && (pid_reg <= 3'd4)
            |=> (pattern_time_reg == 12'd0) && pattern_running_reg)
        else $error("pattern start did not restart the pattern clock");

    a_result_follows_fire: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("processed item produced no result");

endmodule
